@@ hdl/tstb_pkg.sv @@
// Package for the triangle setup and tile binner.
// Holds shared constants, register indexes and the controller/datapath command types.
`timescale 1ns / 1ps
package tstb_pkg;

  localparam int unsigned SUBPIXEL_BITS   = 4;
  localparam int unsigned BIN_WIDTH_LOG2  = 7;
  localparam int unsigned BIN_HEIGHT_LOG2 = 7;
  localparam int unsigned MAX_REC         = 64;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned PIX_W   = 10;  // pixel coordinate 0..1023
  localparam int unsigned BINX_W  = PIX_W - BIN_WIDTH_LOG2;
  localparam int unsigned BINY_W  = PIX_W - BIN_HEIGHT_LOG2;
  localparam int unsigned CNT_W   = $clog2(MAX_REC + 1);

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         bin_col;
    logic [2:0]         bin_row;
    logic signed [31:0] edge_a_const;
    logic signed [31:0] edge_b_const;
    logic signed [31:0] edge_c_const;
    logic [53:0]        x_steps_packed;
    logic [53:0]        y_steps_packed;
    logic [7:0]         box_min_x;
    logic [7:0]         box_max_x;
    logic [7:0]         box_min_y;
    logic [7:0]         box_max_y;
    logic               last_bin;
  } rec_t;

  typedef struct packed {
    logic load;     // capture vertices
    logic setup1;   // products, edge deltas, box
    logic setup2;   // area sign, edge constants
    logic setup3;   // edge values at first bin
    logic advance;  // step to next bin
    logic take;     // current bin kept: pending -> output, bin -> pending
    logic flush;    // pending -> output with last flag
  } cmd_t;

  typedef struct packed {
    logic cull;
    logic kept;
    logic walk_end;
    logic pend_v;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/tstb_if.sv @@
// Valid/ready channel interfaces for triangle items and bin record items.
// Standalone; no package dependency.
`timescale 1ns / 1ps
interface tstb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vert0_x;
  logic signed [15:0] vert0_y;
  logic signed [15:0] vert1_x;
  logic signed [15:0] vert1_y;
  logic signed [15:0] vert2_x;
  logic signed [15:0] vert2_y;
  modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                  input ready);
  modport sink (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                output ready);
endinterface

interface tstb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         bin_col;
  logic [2:0]         bin_row;
  logic signed [31:0] edge_a_const;
  logic signed [31:0] edge_b_const;
  logic signed [31:0] edge_c_const;
  logic [53:0]        x_steps_packed;
  logic [53:0]        y_steps_packed;
  logic [7:0]         box_min_x;
  logic [7:0]         box_max_x;
  logic [7:0]         box_min_y;
  logic [7:0]         box_max_y;
  logic               last_bin;
  modport source (output valid, bin_col, bin_row, edge_a_const, edge_b_const,
                  edge_c_const, x_steps_packed, y_steps_packed, box_min_x, box_max_x,
                  box_min_y, box_max_y, last_bin, input ready);
  modport sink (input valid, bin_col, bin_row, edge_a_const, edge_b_const,
                edge_c_const, x_steps_packed, y_steps_packed, box_min_x, box_max_x,
                box_min_y, box_max_y, last_bin, output ready);
endinterface

@@ hdl/tstb_ctrl.sv @@
// Sequencing state machine of the binner: setup steps, bin walk, final flush.
// Depends on tstb_pkg for command and status types.
`timescale 1ns / 1ps
module tstb_ctrl
  import tstb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SET1  = 3'd1;
  localparam logic [2:0] ST_SET2  = 3'd2;
  localparam logic [2:0] ST_SET3  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SET1;
        end
      end
      ST_SET1: begin
        cmd_o.setup1 = 1'b1;
        state_d      = ST_SET2;
      end
      ST_SET2: begin
        cmd_o.setup2 = 1'b1;
        state_d      = ST_SET3;
      end
      ST_SET3: begin
        if (stat_i.cull) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.setup3 = 1'b1;
          state_d      = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat_i.kept) begin
          cmd_o.advance = 1'b1;
          if (stat_i.walk_end) state_d = ST_FLUSH;
        end else if (!stat_i.pend_v || stat_i.out_free) begin
          cmd_o.take    = 1'b1;
          cmd_o.advance = 1'b1;
          if (stat_i.walk_end) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_v) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_take_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> (!stat_i.pend_v || stat_i.out_free))
    else $error("bin taken while pending record blocked");
  a_flush_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |=> (state_q == ST_IDLE))
    else $error("flush did not end the triangle");
  a_cull_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SET3 && stat_i.cull) |=> (state_q == ST_IDLE))
    else $error("culled triangle entered walk");

endmodule

@@ hdl/tstb_dpath.sv @@
// Datapath of the binner: edge setup, bounding box, bin walk with corner test,
// pending record and output register. Depends on tstb_pkg.
`timescale 1ns / 1ps
module tstb_dpath
  import tstb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [CFG_W-1:0]   width_i,
  input  logic [CFG_W-1:0]   height_i,
  input  logic signed [15:0] vx_i [3],
  input  logic signed [15:0] vy_i [3],
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output rec_t               out_rec_o
);

  localparam int signed SMASK = (1 << SUBPIXEL_BITS) - 1;
  localparam int unsigned BW  = 1 << BIN_WIDTH_LOG2;
  localparam int unsigned BH  = 1 << BIN_HEIGHT_LOG2;

  logic signed [15:0] vx_q [3], vy_q [3];
  logic signed [16:0] dy_q [3], dx_q [3];
  logic signed [33:0] pa_q, pb_q;
  logic signed [32:0] pc1_q [3], pc2_q [3];
  logic [PIX_W-1:0]   xmin_q, xmax_q, ymin_q, ymax_q;
  logic               cull_q, check_q;
  logic [31:0]        c_q [3];
  logic [31:0]        e_q [3], row_q [3];
  logic [BINX_W-1:0]  bx_q;
  logic [BINY_W-1:0]  by_q;
  logic [CNT_W-1:0]   cnt_q;
  rec_t               pend_q, out_q;
  logic               pend_v_q, out_v_q;

  // effective screen limits, minus one
  logic [PIX_W-1:0] wm1, hm1;
  always_comb begin
    if (width_i == '0) wm1 = '0;
    else if (width_i > CFG_W'(1024)) wm1 = PIX_W'(1023);
    else wm1 = PIX_W'(width_i - CFG_W'(1));
    if (height_i == '0) hm1 = '0;
    else if (height_i > CFG_W'(1024)) hm1 = PIX_W'(1023);
    else hm1 = PIX_W'(height_i - CFG_W'(1));
  end

  function automatic logic [PIX_W-1:0] to_pix(input logic signed [15:0] v,
                                               input logic [PIX_W-1:0] lim);
    logic signed [16:0] s;
    s = (17'(v) + 17'(SMASK)) >>> SUBPIXEL_BITS;
    if (s < 0) return '0;
    else if (s > $signed({7'd0, lim})) return lim;
    else return s[PIX_W-1:0];
  endfunction

  // sub-pixel min/max
  logic signed [15:0] mnx, mxx, mny, mxy;
  always_comb begin
    mnx = vx_q[0]; mxx = vx_q[0]; mny = vy_q[0]; mxy = vy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (vx_q[i] < mnx) mnx = vx_q[i];
      if (vx_q[i] > mxx) mxx = vx_q[i];
      if (vy_q[i] < mny) mny = vy_q[i];
      if (vy_q[i] > mxy) mxy = vy_q[i];
    end
  end

  logic [BINX_W-1:0] bxmin, bxmax;
  logic [BINY_W-1:0] bymin, bymax;
  assign bxmin = xmin_q[PIX_W-1:BIN_WIDTH_LOG2];
  assign bxmax = xmax_q[PIX_W-1:BIN_WIDTH_LOG2];
  assign bymin = ymin_q[PIX_W-1:BIN_HEIGHT_LOG2];
  assign bymax = ymax_q[PIX_W-1:BIN_HEIGHT_LOG2];

  // per-edge constants and steps
  logic signed [34:0] cc [3];
  logic [31:0] dyw [3], dxh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cc[i] = 35'(pc1_q[i]) - 35'(pc2_q[i]);
      if (dy_q[i] < 0 || (dx_q[i] == 0 && dy_q[i] > 0)) cc[i] = cc[i] + 35'sd1;
      dyw[i] = 32'(32'($signed(dy_q[i])) <<< BIN_WIDTH_LOG2);
      dxh[i] = 32'(32'($signed(dx_q[i])) <<< BIN_HEIGHT_LOG2);
    end
  end

  // corner test of the current bin
  logic kept;
  always_comb begin
    logic any;
    logic [31:0] e01, e10, e11;
    kept = 1'b1;
    for (int i = 0; i < 3; i++) begin
      e01 = e_q[i] + dxh[i];
      e10 = e_q[i] + dyw[i];
      e11 = e10 + dxh[i];
      any = (e_q[i] != 0 && !e_q[i][31]) || (e01 != 0 && !e01[31]) ||
            (e10 != 0 && !e10[31]) || (e11 != 0 && !e11[31]);
      if (!any) kept = 1'b0;
    end
    if (!check_q) kept = 1'b1;
  end

  logic walk_end, row_end, cnt_full;
  assign row_end  = (bx_q == bxmax);
  assign cnt_full = (cnt_q == CNT_W'(MAX_REC - 1));
  assign walk_end = (row_end && by_q == bymax) || (kept && cnt_full);

  assign stat_o.cull     = cull_q;
  assign stat_o.kept     = kept;
  assign stat_o.walk_end = walk_end;
  assign stat_o.pend_v   = pend_v_q;
  assign stat_o.out_free = !out_v_q || out_ready_i;

  function automatic logic [7:0] box_rel(input logic [PIX_W-1:0] p,
                                         input logic [PIX_W:0] b0,
                                         input int unsigned sz);
    logic signed [PIX_W+2:0] d;
    d = $signed({2'b00, p}) - $signed({1'b0, b0[PIX_W:0]});
    if (d < 0) return '0;
    else if (d > $signed((PIX_W+3)'(sz))) return 8'(sz);
    else return d[7:0];
  endfunction

  // candidate record for the current bin
  rec_t cand;
  logic [PIX_W:0] bx0, by0;
  always_comb begin
    bx0 = (PIX_W+1)'(bx_q) << BIN_WIDTH_LOG2;
    by0 = (PIX_W+1)'(by_q) << BIN_HEIGHT_LOG2;
    cand.bin_col        = 3'(bx_q);
    cand.bin_row        = 3'(by_q);
    cand.edge_a_const   = e_q[0];
    cand.edge_b_const   = e_q[1];
    cand.edge_c_const   = e_q[2];
    cand.x_steps_packed = {dy_q[2][16], dy_q[2], dy_q[1][16], dy_q[1], dy_q[0][16], dy_q[0]};
    cand.y_steps_packed = {dx_q[2][16], dx_q[2], dx_q[1][16], dx_q[1], dx_q[0][16], dx_q[0]};
    cand.box_min_x      = box_rel(xmin_q, bx0, BW);
    cand.box_max_x      = box_rel(xmax_q, bx0, BW);
    cand.box_min_y      = box_rel(ymin_q, by0, BH);
    cand.box_max_y      = box_rel(ymax_q, by0, BH);
    cand.last_bin       = 1'b0;
  end

  // pending record marked as the final one of the triangle
  rec_t pend_last;
  always_comb begin
    pend_last          = pend_q;
    pend_last.last_bin = 1'b1;
  end

  // edge values at the first bin corner
  logic [31:0] e_org [3];
  always_comb begin
    logic signed [28:0] mx, my;
    for (int i = 0; i < 3; i++) begin
      mx = 29'(dy_q[i]) * $signed({1'b0, xmin_q & ~PIX_W'(BW - 1)});
      my = 29'(dx_q[i]) * $signed({1'b0, ymin_q & ~PIX_W'(BH - 1)});
      e_org[i] = c_q[i] + 32'(mx) + 32'(my);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vx_q <= vx_i;
      vy_q <= vy_i;
    end
    if (cmd_i.setup1) begin
      for (int i = 0; i < 3; i++) begin
        dy_q[i]  <= 17'(vy_q[(i + 1) % 3]) - 17'(vy_q[i]);
        dx_q[i]  <= 17'(vx_q[i]) - 17'(vx_q[(i + 1) % 3]);
        pc1_q[i] <= 33'(vy_q[i]) * (33'(vx_q[(i + 1) % 3]) - 33'(vx_q[i]));
        pc2_q[i] <= 33'(vx_q[i]) * (33'(vy_q[(i + 1) % 3]) - 33'(vy_q[i]));
      end
      pa_q   <= (34'(vx_q[2]) - 34'(vx_q[0])) * (34'(vy_q[1]) - 34'(vy_q[0]));
      pb_q   <= (34'(vy_q[2]) - 34'(vy_q[0])) * (34'(vx_q[1]) - 34'(vx_q[0]));
      xmin_q <= to_pix(mnx, wm1);
      xmax_q <= to_pix(mxx, wm1);
      ymin_q <= to_pix(mny, hm1);
      ymax_q <= to_pix(mxy, hm1);
    end
    if (cmd_i.setup2) begin
      cull_q  <= ((35'(pa_q) - 35'(pb_q)) <= 0);
      check_q <= !((bymax - bymin) <= BINY_W'(1) && (bxmax - bxmin) <= BINX_W'(1));
      for (int i = 0; i < 3; i++) c_q[i] <= 32'(cc[i] >>> SUBPIXEL_BITS);
    end
    if (cmd_i.setup3) begin
      e_q   <= e_org;
      row_q <= e_org;
      bx_q  <= bxmin;
      by_q  <= bymin;
    end else if (cmd_i.advance) begin
      if (row_end) begin
        bx_q <= bxmin;
        by_q <= by_q + BINY_W'(1);
        for (int i = 0; i < 3; i++) begin
          row_q[i] <= row_q[i] + dxh[i];
          e_q[i]   <= row_q[i] + dxh[i];
        end
      end else begin
        bx_q <= bx_q + BINX_W'(1);
        for (int i = 0; i < 3; i++) e_q[i] <= e_q[i] + dyw[i];
      end
    end
    if (cmd_i.take) pend_q <= cand;
    if (cmd_i.flush) begin
      out_q <= pend_last;
    end else if (cmd_i.take && pend_v_q) begin
      out_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.setup3) cnt_q <= '0;
      else if (cmd_i.take) cnt_q <= cnt_q + CNT_W'(1);
      if (cmd_i.take) pend_v_q <= 1'b1;
      else if (cmd_i.flush) pend_v_q <= 1'b0;
      if (cmd_i.flush || (cmd_i.take && pend_v_q)) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rec_o   = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_REC))
    else $error("record count past limit");
  a_push_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.flush || (cmd_i.take && pend_v_q)) |=> out_v_q)
    else $error("pushed record not presented");
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> out_q.last_bin)
    else $error("final record missing last flag");

endmodule

@@ hdl/triangle_setup_tile_binner.sv @@
// Triangle setup and tile binner, top level.
// Uses tstb_pkg, tstb_in_if/tstb_out_if, tstb_ctrl and tstb_dpath.
//
// Input channel tri_in carries one triangle item (three signed sub-pixel
// vertices); output channel bin_out carries one record item per kept bin,
// last_bin marking the final record of a triangle. Registers screen_width
// (index 0) and screen_height (index 1) are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i, one write per cycle; the user must write them only while idle (unchecked).
//
// An item goes through three setup steps (products, edge constants, first
// bin values), then a walk over the bins of the bounding box and a flush
// of the pending record. A culled triangle yields nothing. The walk visits
// bins one per cycle through a single set of edge accumulators, holding
// while a kept bin waits for room in the pending and output registers.
//
// Reset returns to idle, clears the output and sets both screen sizes to 1024.
// When bin_out stalls, the walk holds at the next kept bin; one finished
// record waits in the output register and one in the pending stage.
`timescale 1ns / 1ps
module triangle_setup_tile_binner
  import tstb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tstb_in_if.sink          tri_in,
  tstb_out_if.source       bin_out
);

  logic [CFG_W-1:0] width_q, height_q;
  cmd_t  cmd;
  stat_t stat;
  rec_t  rec;
  logic signed [15:0] vx [3], vy [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1024);
      height_q <= CFG_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign vx[0] = tri_in.vert0_x;
  assign vy[0] = tri_in.vert0_y;
  assign vx[1] = tri_in.vert1_x;
  assign vy[1] = tri_in.vert1_y;
  assign vx[2] = tri_in.vert2_x;
  assign vy[2] = tri_in.vert2_y;

  tstb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tri_in.valid),
    .in_ready_o (tri_in.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tstb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .width_i     (width_q),
    .height_i    (height_q),
    .vx_i        (vx),
    .vy_i        (vy),
    .out_ready_i (bin_out.ready),
    .out_valid_o (bin_out.valid),
    .out_rec_o   (rec)
  );

  assign bin_out.bin_col        = rec.bin_col;
  assign bin_out.bin_row        = rec.bin_row;
  assign bin_out.edge_a_const   = rec.edge_a_const;
  assign bin_out.edge_b_const   = rec.edge_b_const;
  assign bin_out.edge_c_const   = rec.edge_c_const;
  assign bin_out.x_steps_packed = rec.x_steps_packed;
  assign bin_out.y_steps_packed = rec.y_steps_packed;
  assign bin_out.box_min_x      = rec.box_min_x;
  assign bin_out.box_max_x      = rec.box_max_x;
  assign bin_out.box_min_y      = rec.box_min_y;
  assign bin_out.box_max_y      = rec.box_max_y;
  assign bin_out.last_bin       = rec.last_bin;

endmodule
